>>> design/fpba_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types of the fit-policy block allocator.
package fpba_pkg;

	localparam int BLOCKS = 16;
	localparam int IDX_W  = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
	localparam int CNT_W  = $clog2(BLOCKS + 1);

	localparam int SIZE_W    = 16;
	localparam int BIDX_W    = 4;
	localparam int POL_W     = 2;
	localparam int BCNT_W    = 5;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 5;

	typedef enum logic [POL_W-1:0] {
		POL_FIRST = 2'd0,
		POL_BEST  = 2'd1,
		POL_WORST = 2'd2
	} policy_t;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_ALLOC = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FIT_POLICY  = 1'b0,
		REG_BLOCK_COUNT = 1'b1
	} reg_idx_t;

	// Table port request: one write and one read address per cycle
	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  waddr;
		logic [SIZE_W-1:0] wdata;
		logic              re;
		logic [IDX_W-1:0]  raddr;
	} mem_req_t;

endpackage

>>> design/fpba_if.sv
`timescale 1ns / 1ps
// Request, response and configuration channel interfaces.
interface fpba_req_if import fpba_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              op;
	logic [BIDX_W-1:0] block_index;
	logic [SIZE_W-1:0] size_value;

	modport source (output valid, op, block_index, size_value, input ready);
	modport sink   (input valid, op, block_index, size_value, output ready);
endinterface

interface fpba_rsp_if import fpba_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              granted;
	logic [BIDX_W-1:0] chosen_block;

	modport source (output valid, granted, chosen_block, input ready);
	modport sink   (input valid, granted, chosen_block, output ready);
endinterface

interface fpba_cfg_if import fpba_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

>>> design/fpba_mem.sv
`timescale 1ns / 1ps
// Remaining-size table: one write port, one read port with registered data.
module fpba_mem import fpba_pkg::*; (
	input  logic              clk,
	input  mem_req_t          mem_req,
	output logic [SIZE_W-1:0] rd_data
);

	logic [SIZE_W-1:0] mem [BLOCKS];

	always_ff @(posedge clk) begin
		if (mem_req.we) begin
			mem[mem_req.waddr] <= mem_req.wdata;
		end
		if (mem_req.re) begin
			rd_data <= mem[mem_req.raddr];
		end
	end

endmodule

>>> design/fpba_ctrl.sv
`timescale 1ns / 1ps
// Sequencer: loads, allocation scan over the table, write-back and response.
module fpba_ctrl import fpba_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	fpba_req_if.sink          alloc_req,
	fpba_rsp_if.source        alloc_rsp,
	input  logic [POL_W-1:0]  fit_policy,
	input  logic [BCNT_W-1:0] block_count,
	output mem_req_t          mem_req,
	input  logic [SIZE_W-1:0] rd_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  issue_q;
	logic [CNT_W-1:0]  limit_q;
	logic [SIZE_W-1:0] size_q;
	logic              found_q;
	logic [IDX_W-1:0]  pick_q;
	logic [SIZE_W-1:0] best_q;
	logic              rd_vld_s1;
	logic [IDX_W-1:0]  rd_idx_s1;
	logic              rsp_vld_q;
	logic              granted_q;
	logic [BIDX_W-1:0] chosen_q;

	logic             load_ok;
	logic             out_free;
	logic             take;
	logic [CNT_W-1:0] limit;

	// scan length saturates at the table depth
	assign limit = (32'(block_count) >= BLOCKS) ? CNT_W'(BLOCKS) : CNT_W'(block_count);
	assign load_ok = (32'(alloc_req.block_index) < BLOCKS);
	assign out_free = !rsp_vld_q || alloc_rsp.ready;

	assign alloc_req.ready      = (state_q == ST_IDLE);
	assign alloc_rsp.valid      = rsp_vld_q;
	assign alloc_rsp.granted    = granted_q;
	assign alloc_rsp.chosen_block = chosen_q;

	// candidate replaces the current pick; lower index wins ties
	always_comb begin
		take = 1'b0;
		if (rd_vld_s1 && (rd_data >= size_q)) begin
			take = !found_q
				|| ((fit_policy == POL_BEST) && (rd_data < best_q))
				|| ((fit_policy == POL_WORST) && (rd_data > best_q));
		end
	end

	always_comb begin
		mem_req.re    = (state_q == ST_SCAN) && (issue_q < limit_q);
		mem_req.raddr = issue_q[IDX_W-1:0];
		if (state_q == ST_FINISH) begin
			mem_req.we    = out_free && found_q;
			mem_req.waddr = pick_q;
			mem_req.wdata = best_q - size_q;
		end else begin
			mem_req.we    = (state_q == ST_IDLE) && alloc_req.valid
				&& (alloc_req.op == OP_LOAD) && load_ok;
			mem_req.waddr = IDX_W'(alloc_req.block_index);
			mem_req.wdata = alloc_req.size_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rd_vld_s1 <= 1'b0;
			rsp_vld_q <= 1'b0;
		end else begin
			if (rsp_vld_q && alloc_rsp.ready && (state_q != ST_FINISH)) begin
				rsp_vld_q <= 1'b0;
			end
			rd_vld_s1 <= mem_req.re;
			rd_idx_s1 <= issue_q[IDX_W-1:0];
			case (state_q)
				ST_IDLE: begin
					if (alloc_req.valid && (alloc_req.op == OP_ALLOC)) begin
						size_q  <= alloc_req.size_value;
						limit_q <= limit;
						issue_q <= '0;
						found_q <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (mem_req.re) begin
						issue_q <= issue_q + CNT_W'(1);
					end
					if (take) begin
						found_q <= 1'b1;
						pick_q  <= rd_idx_s1;
						best_q  <= rd_data;
					end
					if (!mem_req.re && !rd_vld_s1) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						rsp_vld_q <= 1'b1;
						granted_q <= found_q;
						chosen_q  <= found_q ? BIDX_W'(pick_q) : '0;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> design/fit_policy_block_allocator.sv
`timescale 1ns / 1ps
// Operation: a load request is written in the cycle it is accepted and gives no response;
// an allocate request reads the first limit table entries one entry a cycle, limit being
// block_count saturated at the table depth, then makes the last compare, writes back and
// registers its response, waiting while an earlier response is not taken. One request is in work at a time: a
// new allocate is taken only once the last one's response is registered; one load a cycle while idle.
// Reset clears the sequencer, the response valid and both registers; the table is not cleared.
module fit_policy_block_allocator import fpba_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	fpba_req_if.sink   alloc_req,
	fpba_rsp_if.source alloc_rsp,
	fpba_cfg_if.sink   cfg
);

	logic [POL_W-1:0]  fit_policy_q;
	logic [BCNT_W-1:0] block_count_q;
	mem_req_t          mem_req;
	logic [SIZE_W-1:0] rd_data;

	// Configuration is always taken; the user makes writes only while the allocator is idle, unchecked here
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_policy_q  <= POL_W'(POL_FIRST);
			block_count_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_FIT_POLICY:  fit_policy_q  <= cfg.data[POL_W-1:0];
				REG_BLOCK_COUNT: block_count_q <= cfg.data[BCNT_W-1:0];
				default: begin
					// drop writes to unknown registers
				end
			endcase
		end
	end

	// Sequencer: takes loads straight into the table, walks the first block_count entries
	// (saturated at the table depth) for an allocate, keeps the policy's best candidate,
	// then writes back the reduced size and presents the response. The write-back lands
	// before the next request is accepted, so no forwarding is needed on the table.
	fpba_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.alloc_req   (alloc_req),
		.alloc_rsp   (alloc_rsp),
		.fit_policy  (fit_policy_q),
		.block_count (block_count_q),
		.mem_req     (mem_req),
		.rd_data     (rd_data)
	);

	// Remaining-size table with registered read data
	fpba_mem u_mem (
		.clk     (clk),
		.mem_req (mem_req),
		.rd_data (rd_data)
	);

endmodule
